// ----- design/mbe_pkg.sv -----
// Shared constants, types and codes for the Mandelbrot escape-time block.
package mbe_pkg;

  // Fixed-point format: Q3.28 points, Q4.28 bailout, Q12.28 iterates
  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 31;
  localparam int BAIL_W     = 32;
  localparam int CNT_W      = 13;
  localparam int ITER_LIMIT = 4096;
  localparam int Z_W        = 40;
  localparam int OP_W       = 32;
  localparam int PROD_W     = 2 * OP_W;
  localparam int SQ_W       = PROD_W - FRAC_BITS;
  localparam int HUGE_EXP   = 17 + FRAC_BITS / 2;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]          count_t;

  localparam logic [BAIL_W-1:0] BAIL_RESET     = BAIL_W'(32'h4000_0000);
  localparam count_t            MAX_ITER_RESET = CNT_W'(256);

  // Register index, taken from paddr bit 2
  typedef enum logic [0:0] {
    REG_BAIL     = 1'b0,
    REG_MAX_ITER = 1'b1
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_XY   = 5'b00010,
    S_RR   = 5'b00100,
    S_II   = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

endpackage

// ----- design/mbe_point_if.sv -----
// Input channel carrying one point c per item.
interface mbe_point_if;
  logic            valid;
  logic            ready;
  mbe_pkg::coord_t c_real;
  mbe_pkg::coord_t c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

// ----- design/mbe_count_if.sv -----
// Output channel carrying one escape count per item.
interface mbe_count_if;
  logic            valid;
  logic            ready;
  mbe_pkg::count_t iter_count;

  modport source (output valid, output iter_count, input ready);
  modport sink (input valid, input iter_count, output ready);
endinterface

// ----- design/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time counter with one shared 32x32 multiplier.
//
//   channel  | dir | payload                 | handshake
//   ---------+-----+-------------------------+-------------------------
//   point    | in  | c_real, c_imag (Q3.28)  | valid/ready
//   result   | out | iter_count (13 bits)    | valid/ready
//   apb      | in  | bail_radius_sq, max_iter| psel/penable, pready = 1
//
// Each iteration uses the shared multiplier three times (zr*zi, zr*zr,
// zi*zi), one product a cycle.
// The escape test overlaps the first step of the next iteration.
// Reset is synchronous and clears the sequencer, the output valid flag and the
// configuration registers. A finished count waits in the output register, so
// a stalled result side blocks a new point only once a second count is ready.
module mandelbrot_escape_time (
  input  logic                       clk,
  input  logic                       rst,
  mbe_point_if.sink                  point,
  mbe_count_if.source                result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mbe_pkg::ADDR_W-1:0] paddr,
  input  logic [mbe_pkg::DATA_W-1:0] pwdata,
  output logic [mbe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import mbe_pkg::*;

  localparam logic signed [Z_W-1:0] HUGE_RAW = Z_W'(1) << HUGE_EXP;

  // Configuration registers
  logic [BAIL_W-1:0] bail_radius_sq;
  count_t            max_iter;

  // Sequencer and result register
  state_t state;
  logic   out_valid;
  count_t out_count;

  // Iteration datapath
  coord_t                   point_real;
  coord_t                   point_imag;
  logic signed [Z_W-1:0]    z_real;
  logic signed [Z_W-1:0]    z_imag;
  logic signed [PROD_W-1:0] prod;
  logic [SQ_W-1:0]          sq_real;
  logic                     huge;
  logic                     first;
  count_t                   counter;

  logic signed [OP_W-1:0]   mul_a;
  logic signed [OP_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_next;
  logic [SQ_W-1:0]          sq_imag_cur;
  logic [SQ_W:0]            mag_sum;
  logic                     escaped;
  count_t                   limit;
  logic                     stop;
  logic signed [Z_W-1:0]    z_real_next;
  logic signed [Z_W-1:0]    z_imag_next;
  logic                     huge_next;
  logic                     load_out;
  logic                     cfg_write;
  reg_idx_t                 cfg_idx;

  // APB decode
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bail_radius_sq <= BAIL_RESET;
      max_iter       <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_BAIL:     bail_radius_sq <= pwdata[BAIL_W-1:0];
        REG_MAX_ITER: max_iter       <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BAIL:     prdata = DATA_W'(bail_radius_sq);
      REG_MAX_ITER: prdata = DATA_W'(max_iter);
      default:      prdata = '0;
    endcase
  end

  // Select the multiplier operands for this step
  always_comb begin
    case (state)
      S_XY: begin
        mul_a = z_real[OP_W-1:0];
        mul_b = z_imag[OP_W-1:0];
      end
      S_II: begin
        mul_a = z_imag[OP_W-1:0];
        mul_b = z_imag[OP_W-1:0];
      end
      default: begin
        mul_a = z_real[OP_W-1:0];
        mul_b = z_real[OP_W-1:0];
      end
    endcase
  end

  assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Escape test on the squares of the last iterate
  assign sq_imag_cur = prod[PROD_W-1:FRAC_BITS];
  assign mag_sum     = {1'b0, sq_real} + {1'b0, sq_imag_cur};
  assign escaped     = huge || (mag_sum >= (SQ_W+1)'(bail_radius_sq));
  assign limit       = (max_iter > CNT_W'(ITER_LIMIT)) ? CNT_W'(ITER_LIMIT) : max_iter;
  assign stop        = !first && (escaped || (counter >= limit));

  // New iterate: real part from the squares, imaginary part from zr*zi
  assign z_real_next = Z_W'(point_real) + $signed(Z_W'(sq_real))
                       - $signed(Z_W'(sq_imag_cur));
  assign z_imag_next = Z_W'(point_imag) + Z_W'(prod >>> (FRAC_BITS - 1));

  // Flag an iterate too large to square
  assign huge_next = (z_real >= HUGE_RAW) || (z_real <= -HUGE_RAW) ||
                     (z_imag >= HUGE_RAW) || (z_imag <= -HUGE_RAW);

  // Move a finished count into the output register once it is free
  assign load_out = (state == S_HOLD) && (!out_valid || result.ready);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (point.valid) state <= S_XY;
        S_XY:   state <= stop ? S_HOLD : S_RR;
        S_RR:   state <= S_II;
        S_II:   state <= S_XY;
        S_HOLD: if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (point.valid) begin
          point_real <= point.c_real;
          point_imag <= point.c_imag;
          z_real     <= '0;
          z_imag     <= '0;
          prod       <= '0;
          sq_real    <= '0;
          huge       <= 1'b0;
          first      <= 1'b1;
          counter    <= CNT_W'(1);
        end
      end
      S_XY: begin
        if (!stop) begin
          counter <= counter + CNT_W'(1);
          first   <= 1'b0;
          z_real  <= z_real_next;
          prod    <= prod_next;
        end
      end
      S_RR: begin
        z_imag <= z_imag_next;
        prod   <= prod_next;
      end
      S_II: begin
        sq_real <= prod[PROD_W-1:FRAC_BITS];
        prod    <= prod_next;
        huge    <= huge_next;
      end
      S_HOLD: begin
        if (load_out) begin
          out_count <= counter;
        end
      end
      default: ;
    endcase
  end

  assign point.ready       = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.iter_count = out_count;

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the escape-time block: directed and random points checked against a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  // An iterate this large escapes without its square being formed
  localparam int     HUGE_SHIFT = 17 + FRAC_BITS / 2;
  localparam coord_t C_MIN      = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX      = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [31:0] BAIL_FOUR = 32'h4000_0000;
  localparam logic [31:0] BAIL_TOP  = 32'hFFFF_FFFF;

  typedef struct {
    coord_t cr;
    coord_t ci;
    count_t count;
  } escape_exp_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  mbe_point_if point_ch ();
  mbe_count_if result_ch ();

  // Shadow configuration used by the predictor
  logic [31:0]         bail_sq_cfg;
  count_t              max_iter_cfg;

  escape_exp_t         pending_counts[$];
  int                  errors = 0;
  longint              cycles = 0;
  longint              cycle_budget = 50000;
  bit                  idle_on = 1'b0;
  int                  hold_left = 0;

  mandelbrot_escape_time dut (
    .clk     (clk),
    .rst     (rst),
    .point   (point_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Work out the escape count of one point under the shadow configuration
  function automatic count_t escape_count(input coord_t cr, input coord_t ci);
    logic signed [127:0] zr, zi, nr, ni, mag_sq, huge_v;
    int unsigned lim, n;
    bit escaped;
    lim = (max_iter_cfg > ITER_LIMIT) ? ITER_LIMIT : max_iter_cfg;
    zr = '0;
    zi = '0;
    n = 1;
    huge_v = 128'sd1 <<< HUGE_SHIFT;
    do begin
      n++;
      // Arithmetic shift floors each product
      nr = cr + ((zr * zr) >>> FRAC_BITS) - ((zi * zi) >>> FRAC_BITS);
      ni = ci + ((zr * zi) >>> (FRAC_BITS - 1));
      zr = nr;
      zi = ni;
      if (nr >= huge_v || -nr >= huge_v || ni >= huge_v || -ni >= huge_v) begin
        escaped = 1'b1;
      end else begin
        mag_sq = ((nr * nr) >>> FRAC_BITS) + ((ni * ni) >>> FRAC_BITS);
        escaped = (mag_sq >= $signed({96'd0, bail_sq_cfg}));
      end
    end while (!escaped && n < lim);
    return count_t'(n);
  endfunction

  function automatic coord_t fx(input real v);
    return coord_t'($rtoi(v * (2.0 ** FRAC_BITS)));
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stall the result side at random while idling is on
  always @(negedge clk) begin
    if (hold_left == 0 && idle_on && $urandom_range(0, 99) < 15)
      hold_left = gap_len();
    if (hold_left > 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted count with the oldest expectation
  always @(posedge clk) begin : check_counts
    escape_exp_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_counts.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("count %0d arrived with no point outstanding", result_ch.iter_count);
      end else begin
        want = pending_counts.pop_front();
        if (result_ch.iter_count !== want.count) begin
          errors++;
          if (errors <= 10)
            $display("c=(%0d,%0d): count expected %0d, got %0d",
                     want.cr, want.ci, want.count, result_ch.iter_count);
        end
      end
    end
  end

  // End the run if the block stops making progress
  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_budget) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one point and record its expected count once accepted
  task automatic send_point(input coord_t cr, input coord_t ci);
    int gap;
    int lim;
    gap = idle_on ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      point_ch.valid  <= 1'b0;
      point_ch.c_real <= coord_t'($urandom);
      point_ch.c_imag <= coord_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    point_ch.valid  <= 1'b1;
    point_ch.c_real <= cr;
    point_ch.c_imag <= ci;
    do @(posedge clk); while (point_ch.ready !== 1'b1);
    pending_counts.push_back('{cr, ci, escape_count(cr, ci)});
    lim = (max_iter_cfg > ITER_LIMIT) ? ITER_LIMIT : int'(max_iter_cfg);
    cycle_budget += 4 * (3 * lim + 3) + 200;
  endtask

  // Drop valid and hold until every expected count has come
  task automatic drain_counts();
    @(negedge clk);
    point_ch.valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_reg(input reg_idx_t idx, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      errors++;
      if (errors <= 10)
        $display("register %s read expected %h, got %h", idx.name(), want, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, update the shadow copy and read it back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    logic [31:0] stored;
    stored = (idx == REG_BAIL) ? data : {19'd0, data[CNT_W-1:0]};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_BAIL) bail_sq_cfg = stored;
    else max_iter_cfg = stored[CNT_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_reg(idx, stored);
    cycle_budget += 100;
  endtask

  task automatic configure_block(input logic [31:0] bail, input logic [31:0] max_it);
    drain_counts();
    write_reg(REG_BAIL, bail);
    write_reg(REG_MAX_ITER, max_it);
  endtask

  // Mostly points near the set, with some full-range noise and some at the imaginary extremes
  task automatic send_random_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      send_point(coord_t'(int'($urandom_range(0, 671088640)) - 536870912),
                 coord_t'(int'($urandom_range(0, 671088640)) - 335544320));
    else if (r < 90)
      send_point(coord_t'($urandom), coord_t'($urandom));
    else
      send_point(coord_t'(int'($urandom_range(0, 4095)) - 2048),
                 (r < 95) ? C_MIN : C_MAX);
  endtask

  task automatic test_register_access();
    check_reg(REG_BAIL, BAIL_FOUR);
    check_reg(REG_MAX_ITER, 32'd256);
  endtask

  // Field extremes and well-known points under the reset configuration
  task automatic test_directed_points();
    idle_on = 1'b0;
    send_point('0, '0);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MAX);
    send_point(C_MAX, C_MIN);
    send_point(fx(-2.0), '0);
    send_point(fx(0.25), '0);
    send_point(fx(-1.0), '0);
    send_point('0, fx(1.0));
    send_point(fx(-0.75), fx(0.1));
    send_point(fx(0.3), fx(-0.5));
    send_point(coord_t'(1), coord_t'(-1));
    send_point(fx(-0.1), fx(0.65));
    drain_counts();
  endtask

  // Zero bailout, loop limits below two, of two, at the ceiling and above it
  task automatic test_limits_and_bailout();
    idle_on = 1'b1;
    configure_block(32'd0, 32'd256);
    send_point('0, '0);
    send_point(fx(-1.0), '0);
    configure_block(BAIL_FOUR, 32'd0);
    send_point('0, '0);
    // Upper data bits set, low field holds one
    configure_block(BAIL_FOUR, 32'hFFFF_E001);
    send_point('0, '0);
    configure_block(BAIL_FOUR, 32'h0000_1FFF);
    send_point('0, '0);
    configure_block(BAIL_FOUR, 32'd4096);
    send_point(fx(-1.0), '0);
    configure_block(BAIL_TOP, 32'd2);
    send_point(fx(0.25), '0);
    drain_counts();
  endtask

  // Iterates that grow too large for the square under the widest bailout
  task automatic test_escape_shortcut();
    idle_on = 1'b1;
    configure_block(BAIL_TOP, 32'd256);
    send_point(fx(-3.9), '0);
    send_point('0, fx(3.9));
    send_point(fx(2.0), fx(2.0));
    send_point(C_MIN, '0);
    send_point(fx(0.3), fx(0.2));
    drain_counts();
  endtask

  // Random points at the default bailout, pausing now and then for a full drain
  task automatic test_random_region();
    idle_on = 1'b1;
    configure_block(BAIL_FOUR, 32'd64);
    for (int i = 0; i < 250; i++) begin
      send_random_point();
      if (i % 60 == 59)
        drain_counts();
    end
    drain_counts();
  endtask

  // Random points under a series of random settings
  task automatic test_random_settings();
    logic [31:0] bail;
    logic [31:0] max_it;
    for (int round = 0; round < 5; round++) begin
      case ($urandom_range(0, 3))
        0:       bail = $urandom;
        1:       bail = $urandom_range(0, 32'h1000_0000);
        2:       bail = BAIL_FOUR;
        default: bail = BAIL_TOP;
      endcase
      max_it = (round == 0) ? 32'd2 : $urandom_range(2, 300);
      idle_on = (round != 2);
      configure_block(bail, max_it);
      repeat (100) send_random_point();
    end
    drain_counts();
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    point_ch.valid   = 1'b0;
    point_ch.c_real  = '0;
    point_ch.c_imag  = '0;
    result_ch.ready  = 1'b0;
    // Reset values of the two registers
    bail_sq_cfg      = BAIL_FOUR;
    max_iter_cfg     = count_t'(256);
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_register_access();
    test_directed_points();
    test_limits_and_bailout();
    test_escape_shortcut();
    test_random_region();
    test_random_settings();

    drain_counts();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
design/mbe_pkg.sv
design/mbe_point_if.sv
design/mbe_count_if.sv
design/mandelbrot_escape_time.sv
tb/sv/tb_top.sv
